[hw/rtl/tkvfl_pkg.sv]
`default_nettype none
package tkvfl_pkg;
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SET_RD,
    BK_SET_CHK,
    BK_GET_RD,
    BK_GET_CHK,
    BK_GET_VAL,
    BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

[hw/rtl/tkvfl_ram.sv]
`default_nettype none
module tkvfl_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/tkvfl_front.sv]
`default_nettype none
module tkvfl_front #(
  parameter int KeyWidth = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                req_type,
  input  wire logic [3:0]          key_index,
  input  wire logic [31:0]         data_word,
  input  wire logic [30:0]         stamp,
  input  wire logic                in_range,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output logic [KeyWidth+64:0]     q_data
);
  // two-entry queue: {in_range, type, key, word, stamp}
  localparam int W = KeyWidth + 65;
  logic [W-1:0] slot [2];
  logic         rd_ptr, wr_ptr;
  logic [1:0]   fill;
  logic [W-1:0] packed_req;
  logic         push, pop;

  assign packed_req = {in_range, req_type, KeyWidth'(key_index), data_word, stamp};
  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_data   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // hold payload slots
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= packed_req;
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/tkvfl_back.sv]
`default_nettype none
module tkvfl_back #(
  parameter int KeyWidth = 5,
  parameter int NumKeys = 16,
  parameter int HistoryDepth = 64,
  parameter int ValueWidth = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire logic [KeyWidth+64:0] q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   found,
  output logic [31:0]            read_word,
  output logic [1:0]             status
);
  import tkvfl_pkg::*;

  localparam int KIdx = (NumKeys > 1) ? $clog2(NumKeys) : 1;
  localparam int CntW = $clog2(HistoryDepth + 1);
  localparam int Entries = NumKeys * HistoryDepth;
  localparam int AddrW = (Entries > 1) ? $clog2(Entries) : 1;

  bk_state_t state, state_next;

  // current request fields
  logic             r_range, r_type;
  logic [KeyWidth-1:0] r_key;
  logic [31:0]      r_word;
  logic [30:0]      r_stamp;
  logic [KIdx-1:0]  key_sel;

  logic [CntW-1:0]  count [NumKeys];
  logic [CntW-1:0]  cur_cnt;
  logic [CntW-1:0]  lo, hi, lo_next, hi_next, mid;

  logic             t_we;
  logic [AddrW-1:0] t_waddr, raddr;
  logic [30:0]      t_rdata;
  logic [ValueWidth-1:0] v_rdata;

  logic             res_found;
  logic [31:0]      res_word;
  logic [1:0]       res_status;
  logic             load_res;

  assign key_sel = KIdx'(r_key);
  assign cur_cnt = count[key_sel];
  assign mid     = lo + ((hi - lo) >> 1);
  assign q_ready = (state == BK_IDLE);

  // flat entry address of key and slot
  function automatic logic [AddrW-1:0] ent_addr(input logic [KIdx-1:0] k,
                                                input logic [CntW-1:0] s);
    logic [AddrW+CntW:0] a;
    a = (AddrW+CntW+1)'(k) * (AddrW+CntW+1)'(HistoryDepth) + (AddrW+CntW+1)'(s);
    return a[AddrW-1:0];
  endfunction

  tkvfl_ram #(.Width(31), .Depth(Entries)) u_times (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(r_stamp),
    .raddr(raddr), .rdata(t_rdata)
  );
  tkvfl_ram #(.Width(ValueWidth), .Depth(Entries)) u_values (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(ValueWidth'(r_word)),
    .raddr(raddr), .rdata(v_rdata)
  );

  // state register, output valid and per-key history counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NumKeys; i++) count[i] <= '0;
    end else begin
      state <= state_next;
      if (load_res) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (t_we) count[key_sel] <= cur_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      {r_range, r_type, r_key, r_word, r_stamp} <= q_data;
    end
    lo <= lo_next;
    hi <= hi_next;
    if (load_res) begin
      found <= res_found;
      read_word <= res_word;
      status <= res_status;
    end
  end

  // next state, search bounds and results
  always_comb begin
    state_next = state;
    lo_next = lo;
    hi_next = hi;
    t_we = 1'b0;
    t_waddr = ent_addr(key_sel, cur_cnt);
    raddr = ent_addr(key_sel, mid);
    load_res = 1'b0;
    res_found = 1'b0;
    res_word = '0;
    res_status = ST_OK;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) state_next = (q_data[KeyWidth+63] == REQ_GET) ? BK_GET_RD : BK_SET_RD;
      end
      BK_SET_RD: begin
        raddr = ent_addr(key_sel, cur_cnt - 1'b1);
        if (!r_range || cur_cnt >= CntW'(HistoryDepth)) begin
          res_status = ST_FULL;
          load_res = 1'b1;
          state_next = BK_DONE;
        end else if (cur_cnt == '0) begin
          t_we = 1'b1;
          load_res = 1'b1;
          state_next = BK_DONE;
        end else begin
          state_next = BK_SET_CHK;
        end
      end
      BK_SET_CHK: begin
        if (r_stamp <= t_rdata) res_status = ST_ORDER;
        else t_we = 1'b1;
        load_res = 1'b1;
        state_next = BK_DONE;
      end
      BK_GET_RD: begin
        lo_next = '0;
        hi_next = r_range ? cur_cnt : '0;
        state_next = BK_GET_CHK;
      end
      BK_GET_CHK: begin
        // read at mid issued; compare next cycle
        if (lo >= hi) begin
          raddr = ent_addr(key_sel, lo - 1'b1);
          if (lo == '0) begin
            load_res = 1'b1;
            state_next = BK_DONE;
          end else begin
            state_next = BK_GET_VAL;
          end
        end else begin
          state_next = BK_GET_VAL;
          lo_next = lo;
        end
      end
      BK_GET_VAL: begin
        if (lo >= hi) begin
          res_found = 1'b1;
          res_word = 32'(v_rdata);
          load_res = 1'b1;
          state_next = BK_DONE;
        end else begin
          if (t_rdata <= r_stamp) lo_next = mid + 1'b1;
          else hi_next = mid;
          state_next = BK_GET_CHK;
        end
      end
      BK_DONE: begin
        if (!out_valid || out_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
    if (load_res && out_valid && !out_ready) begin
      load_res = 1'b0;
      t_we = 1'b0;
      state_next = state;
      lo_next = lo;
      hi_next = hi;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/timestamped_kv_floor_lookup.sv]
`default_nettype none
// Versioned key-value table: a set appends (stamp, value) to one key's history,
// a get binary-searches that history for the latest stamp not above the query.
// One request is served at a time by the back end; a two-entry queue lets
// the next request be taken while one is at work. The steps of a get's search
// are paced by the single registered read port of the entry memories.
module timestamped_kv_floor_lookup #(
  parameter int NUM_KEYS = 16,
  parameter int HISTORY_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [3:0]  key_index,
  input  wire logic [31:0] data_word,
  input  wire logic [30:0] stamp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             found,
  output logic [31:0]      read_word,
  output logic [1:0]       status
);
  localparam int KeyWidth = 5;
  logic                 q_valid, q_ready;
  logic [KeyWidth+64:0] q_data;
  logic                 in_range;

  assign in_range = (32'(key_index) < NUM_KEYS);

  tkvfl_front #(.KeyWidth(KeyWidth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .key_index, .data_word,
    .stamp, .in_range, .q_valid, .q_ready, .q_data
  );

  tkvfl_back #(
    .KeyWidth(KeyWidth), .NumKeys(NUM_KEYS), .HistoryDepth(HISTORY_DEPTH),
    .ValueWidth(VALUE_WIDTH)
  ) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .out_valid, .out_ready,
    .found, .read_word, .status
  );
endmodule
`default_nettype wire

[tb/tb_timestamped_kv_floor_lookup.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_timestamped_kv_floor_lookup;
  import tkvfl_pkg::*;

  localparam int NUM_KEYS      = 16;
  localparam int HISTORY_DEPTH = 64;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic        found;
    logic [31:0] word;
    status_t     stat;
  } lookup_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        req_type;
  logic [3:0]  key_index;
  logic [31:0] data_word;
  logic [30:0] stamp;
  logic        out_valid;
  logic        out_ready;
  logic        found;
  logic [31:0] read_word;
  logic [1:0]  status;

  // predictor copy of the table
  int unsigned    hist_len [NUM_KEYS];
  logic [30:0]    hist_time [NUM_KEYS][HISTORY_DEPTH];
  logic [31:0]    hist_word [NUM_KEYS][HISTORY_DEPTH];
  lookup_result_t pending_results[$];

  int  mismatches;
  int  cycles;
  bit  hold_off;
  int  hold_cycles;

  timestamped_kv_floor_lookup u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .key_index (key_index),
    .data_word (data_word),
    .stamp     (stamp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .read_word (read_word),
    .status    (status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // compute the expected result of one request and update the table
  function automatic lookup_result_t predict_lookup(logic op, logic [3:0] key,
                                                    logic [31:0] word,
                                                    logic [30:0] ts);
    lookup_result_t r;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    r = '{found: 1'b0, word: 32'd0, stat: ST_OK};
    if (key >= NUM_KEYS) begin
      if (op == REQ_SET) r.stat = ST_FULL;
      return r;
    end
    n = hist_len[key];
    if (op == REQ_SET) begin
      if (n >= HISTORY_DEPTH) begin
        r.stat = ST_FULL;
      end else if (n > 0 && ts <= hist_time[key][n-1]) begin
        r.stat = ST_ORDER;
      end else begin
        hist_time[key][n] = ts;
        hist_word[key][n] = word;
        hist_len[key] = n + 1;
      end
      return r;
    end
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (hist_time[key][mid] <= ts) lo = mid + 1;
      else hi = mid;
    end
    if (lo != 0) begin
      r.found = 1'b1;
      r.word  = hist_word[key][lo-1];
    end
    return r;
  endfunction

  // offer one request and hold it until accepted; valid stays up for a follower
  task automatic send_request(logic op, logic [3:0] key, logic [31:0] word,
                              logic [30:0] ts);
    in_valid  <= 1'b1;
    req_type  <= op;
    key_index <= key;
    data_word <= word;
    stamp     <= ts;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, predict_lookup(op, key, word, ts)};
  endtask

  // drop valid and wait
  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // random gap between bursts
  task automatic maybe_gap(ref int burst);
    if (burst == 0) begin
      burst = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
    burst--;
  endtask

  task automatic test_directed();
    send_request(REQ_GET, 4'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(REQ_SET, 4'd0, 32'hDEAD_BEEF, 31'd100);
    send_request(REQ_GET, 4'd0, 32'd0, 31'd99);
    send_request(REQ_GET, 4'd0, 32'd0, 31'd100);
    send_request(REQ_GET, 4'd0, 32'd0, 31'h7FFF_FFFF);
    send_request(REQ_SET, 4'd0, 32'h1234_5678, 31'd100);
    send_request(REQ_SET, 4'd0, 32'h1234_5678, 31'd50);
    send_request(REQ_SET, 4'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(REQ_GET, 4'd0, 32'd0, 31'h7FFF_FFFE);
    send_request(REQ_GET, 4'd0, 32'd0, 31'h7FFF_FFFF);
    send_request(REQ_SET, 4'd15, 32'd0, 31'd0);
    send_request(REQ_GET, 4'd15, 32'd0, 31'd0);
    send_request(REQ_SET, 4'd15, 32'd1, 31'd0);
    send_request(REQ_SET, 4'd7, 32'hAAAA_5555, 31'h5555_5555);
    send_request(REQ_GET, 4'd7, 32'd0, 31'h2AAA_AAAA);
    send_request(REQ_GET, 4'd7, 32'd0, 31'h5555_5555);
  endtask

  // fill one key to capacity, then check that further sets are refused as full and query it
  task automatic test_full_history();
    int i;
    int burst;
    burst = 0;
    for (i = 0; i < HISTORY_DEPTH; i++) begin
      maybe_gap(burst);
      send_request(REQ_SET, 4'd3, $urandom(), 31'(i * 1000 + 5));
    end
    send_request(REQ_SET, 4'd3, 32'h0, 31'h7FFF_FFFF);
    send_request(REQ_SET, 4'd3, 32'h0, 31'd0);
    for (i = 0; i < 16; i++)
      send_request(REQ_GET, 4'd3, $urandom(), 31'($urandom_range(0, 70000)));
  endtask

  // receiver holds off long while sender keeps offering
  task automatic test_backpressure();
    int i;
    hold_cycles = 300;
    hold_off = 1'b1;
    for (i = 0; i < 20; i++)
      send_request(1'($urandom_range(0, 1)), 4'($urandom_range(8, 11)), $urandom(),
                   31'($urandom_range(0, 50000)));
    wait_drained();
    idle_cycles(30);
  endtask

  // mostly increasing sets and gets near stored stamps, some noise
  task automatic test_random(int total);
    logic [30:0] last_ts [NUM_KEYS];
    int i;
    int burst;
    int k;
    logic [30:0] ts;
    burst = 0;
    for (k = 0; k < NUM_KEYS; k++) last_ts[k] = 31'($urandom_range(0, 1000));
    for (i = 0; i < total; i++) begin
      maybe_gap(burst);
      k = $urandom_range(0, NUM_KEYS - 1);
      if (i == total / 2) begin
        wait_drained();
        idle_cycles(5);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          ts = last_ts[k] + 31'($urandom_range(1, 400));
          if ($urandom_range(0, 40) == 0) ts = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
          last_ts[k] = ts;
          send_request(REQ_SET, 4'(k), $urandom(), ts);
        end
        4: send_request(REQ_SET, 4'(k), $urandom(), 31'($urandom()));
        9: send_request(REQ_GET, 4'(k), $urandom(), 31'($urandom()));
        default: begin
          ts = last_ts[k] - 31'($urandom_range(0, 3000));
          if ($urandom_range(0, 3) == 0) ts = last_ts[k] + 31'($urandom_range(0, 3));
          send_request(REQ_GET, 4'(k), $urandom(), ts);
        end
      endcase
    end
  endtask

  // receiver stall pattern, with a long hold-off on demand
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
      if (hold_cycles == 0) hold_off <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else if (cycles % 512 < 128) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // compare each delivered result with the oldest expectation
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result found=%0b word=%h status=%0d",
                                       found, read_word, status);
      end else begin
        want = pending_results.pop_front();
        if (want.found !== found || want.word !== read_word || want.stat !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp found=%0b word=%h status=%0d, got %0b %h %0d",
                     want.found, want.word, want.stat, found, read_word, status);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int k;
    mismatches = 0;
    cycles     = 0;
    hold_off   = 1'b0;
    hold_cycles = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_SET;
    key_index  = 4'd0;
    data_word  = 32'd0;
    stamp      = 31'd0;
    for (k = 0; k < NUM_KEYS; k++) hist_len[k] = 0;
    idle_cycles(3);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_history();
    test_backpressure();
    test_random(1230);
    wait_drained();
    idle_cycles(40);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
